// ===== src/mkd_pkg.sv =====
// Shared types, constants and the code table for the Morse key decoder.
`timescale 1ns / 1ps

package mkd_pkg;

    localparam int MSG_DEPTH  = 32;
    localparam int TIMER_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int MSG_CNT_W  = $clog2(MSG_DEPTH + 1);
    localparam int MSG_IDX_W  = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
    localparam int SEQ_MAX    = 6;
    localparam int CODE_NUM   = 36;
    localparam int SYM_W      = 7;

    localparam logic [2:0] SEQ_OVF = 3'd7;

    localparam logic [SYM_W-1:0] ASCII_A     = 7'h41;
    localparam logic [SYM_W-1:0] ASCII_0     = 7'h30;
    localparam logic [SYM_W-1:0] ASCII_SPACE = 7'h20;

    localparam logic [2:0] CFG_DOT_MAX  = 3'd0;
    localparam logic [2:0] CFG_TIMEOUT  = 3'd1;
    localparam logic [2:0] CFG_GLITCH   = 3'd2;
    localparam logic [2:0] CFG_LONG     = 3'd3;
    localparam logic [2:0] CFG_ENTER_EN = 3'd4;

    localparam logic [CFG_W-1:0] DOT_MAX_RST = 16'd400;
    localparam logic [CFG_W-1:0] TIMEOUT_RST = 16'd1000;
    localparam logic [CFG_W-1:0] GLITCH_RST  = 16'd50;
    localparam logic [CFG_W-1:0] LONG_RST    = 16'd1000;

    typedef enum logic [2:0] {
        EV_DOT     = 3'd0,
        EV_DASH    = 3'd1,
        EV_CHAR    = 3'd2,
        EV_UNKNOWN = 3'd3,
        EV_SPACE   = 3'd4,
        EV_MSG     = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        OUT_ELEM,
        OUT_DEC,
        OUT_SPACE,
        OUT_MSG
    } out_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELEM,
        ST_DEC,
        ST_SPACE,
        ST_SEND_RD,
        ST_SEND_OUT
    } state_t;

    typedef struct packed {
        logic     accept;
        logic     emit;
        out_sel_t out_sel;
        logic     emit_last;
        logic     send_next;
        logic     send_end;
    } dp_cmd_t;

    typedef struct packed {
        logic elem_do;
        logic dec_do;
        logic space_do;
        logic send_do;
        logic send_last;
        logic out_free;
    } dp_status_t;

    localparam logic [2:0] CODE_LEN [CODE_NUM] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
        3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
        3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
    };

    localparam logic [5:0] CODE_BITS [CODE_NUM] = '{
        6'd2,  6'd1,  6'd5,  6'd1,  6'd0,  6'd4,  6'd3,  6'd0,  6'd0,  6'd14,
        6'd5,  6'd2,  6'd3,  6'd1,  6'd7,  6'd6,  6'd11, 6'd2,  6'd0,  6'd1,
        6'd4,  6'd8,  6'd6,  6'd9,  6'd13, 6'd3,
        6'd31, 6'd30, 6'd28, 6'd24, 6'd16, 6'd0,  6'd1,  6'd3,  6'd7,  6'd15
    };

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // Bit i of bits is element i, set for a dash; returns 0 when no entry matches.
    function automatic logic [SYM_W-1:0] code_lookup(input logic [5:0] bits,
                                                     input logic [2:0] cnt);
        logic [SYM_W-1:0] sym;
        logic [5:0]       mask;
        sym  = '0;
        mask = 6'((7'd1 << cnt) - 7'd1);
        for (int i = 0; i < CODE_NUM; i++) begin
            if (cnt == CODE_LEN[i] && (bits & mask) == CODE_BITS[i]) begin
                sym = (i < 26) ? SYM_W'(ASCII_A + i) : SYM_W'(ASCII_0 + i - 26);
            end
        end
        return sym;
    endfunction

endpackage

// ===== src/mkd_ctrl.sv =====
// Controller state machine sequencing the results of one item.
`timescale 1ns / 1ps

module mkd_ctrl
    import mkd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_ELEM;
                end
            end
            ST_ELEM: begin
                if (!status.elem_do || status.out_free) begin
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                if (!status.dec_do || status.out_free) begin
                    state_next = ST_SPACE;
                end
            end
            ST_SPACE: begin
                if (!status.space_do || status.out_free) begin
                    state_next = status.send_do ? ST_SEND_RD : ST_IDLE;
                end
            end
            ST_SEND_RD: begin
                state_next = ST_SEND_OUT;
            end
            ST_SEND_OUT: begin
                if (status.out_free) begin
                    state_next = status.send_last ? ST_IDLE : ST_SEND_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_ELEM: begin
                cmd.out_sel   = OUT_ELEM;
                cmd.emit      = status.elem_do && status.out_free;
                cmd.emit_last = !(status.dec_do || status.space_do || status.send_do);
            end
            ST_DEC: begin
                cmd.out_sel   = OUT_DEC;
                cmd.emit      = status.dec_do && status.out_free;
                cmd.emit_last = !(status.space_do || status.send_do);
            end
            ST_SPACE: begin
                cmd.out_sel   = OUT_SPACE;
                cmd.emit      = status.space_do && status.out_free;
                cmd.emit_last = !status.send_do;
            end
            ST_SEND_RD: begin
                cmd.out_sel = OUT_MSG;
            end
            ST_SEND_OUT: begin
                cmd.out_sel   = OUT_MSG;
                cmd.emit      = status.out_free;
                cmd.emit_last = status.send_last;
                cmd.send_next = status.out_free && !status.send_last;
                cmd.send_end  = status.out_free && status.send_last;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/mkd_datapath.sv =====
// Datapath: timers, element sequence, message store, settings and output register.
`timescale 1ns / 1ps

module mkd_datapath
    import mkd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             key_level,
    input  logic             enter_level,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);

    logic [CFG_W-1:0] dot_max_reg, timeout_reg, glitch_reg, long_reg;
    logic             enter_en_reg;

    logic                  key_prev_reg, key_prev_next;
    logic [TIMER_BITS-1:0] key_hold_reg, key_hold_next;
    logic [5:0]            bits_reg, bits_next;
    logic [2:0]            seq_cnt_reg, seq_cnt_next;
    logic                  pend_reg, pend_next;
    logic [TIMER_BITS-1:0] age_reg, age_next;
    logic                  enter_prev_reg, enter_prev_next;
    logic [TIMER_BITS-1:0] enter_hold_reg, enter_hold_next;

    logic             elem_do_reg, elem_do_next;
    logic             dash_reg, dash_next;
    logic             dec_do_reg, dec_do_next;
    logic [SYM_W-1:0] dec_sym_reg, dec_sym_next;
    logic             space_do_reg, space_do_next;
    logic             send_do_reg, send_do_next;

    logic [SYM_W-1:0]     msg_mem [MSG_DEPTH];
    logic [MSG_CNT_W-1:0] msg_cnt_reg;
    logic [MSG_IDX_W-1:0] rd_idx_reg;
    logic [SYM_W-1:0]     rd_data_reg;

    logic                  m_tvalid_reg;
    logic [2:0]            m_event_reg;
    logic [SYM_W-1:0]      m_sym_reg;
    logic                  m_tlast_reg;

    logic [TIMER_BITS-1:0] age_inc, dur_key, dur_enter;
    logic [5:0]            bits_elem;
    logic [2:0]            cnt_elem;
    logic                  dec_store;
    logic [MSG_CNT_W-1:0]  cnt_after_dec;
    logic                  store_we;
    logic [SYM_W-1:0]      store_data;
    event_t                out_event;
    logic [SYM_W-1:0]      out_sym;
    logic                  msg_not_full;

    assign msg_not_full = msg_cnt_reg < MSG_CNT_W'(MSG_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_max_reg  <= DOT_MAX_RST;
            timeout_reg  <= TIMEOUT_RST;
            glitch_reg   <= GLITCH_RST;
            long_reg     <= LONG_RST;
            enter_en_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DOT_MAX:  dot_max_reg  <= cfg_data;
                CFG_TIMEOUT:  timeout_reg  <= cfg_data;
                CFG_GLITCH:   glitch_reg   <= cfg_data;
                CFG_LONG:     long_reg     <= cfg_data;
                CFG_ENTER_EN: enter_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        age_inc   = pend_reg ? sat_inc(age_reg) : age_reg;
        dur_key   = sat_inc(key_hold_reg);
        dur_enter = sat_inc(enter_hold_reg);

        key_hold_next = key_hold_reg;
        bits_elem     = bits_reg;
        cnt_elem      = seq_cnt_reg;
        pend_next     = pend_reg;
        age_next      = age_inc;
        elem_do_next  = 1'b0;
        dash_next     = 1'b0;

        if (!key_level && key_prev_reg) begin
            key_hold_next = '0;
        end else if (!key_level) begin
            key_hold_next = dur_key;
        end else if (!key_prev_reg && dur_key > glitch_reg) begin
            elem_do_next = 1'b1;
            dash_next    = dur_key > dot_max_reg;
            if (seq_cnt_reg < 3'(SEQ_MAX)) begin
                bits_elem = bits_reg | (6'(dash_next) << seq_cnt_reg);
                cnt_elem  = seq_cnt_reg + 3'd1;
            end else begin
                cnt_elem = SEQ_OVF;
            end
            pend_next = 1'b1;
            age_next  = '0;
        end
        key_prev_next = key_level;

        dec_do_next  = key_level && cnt_elem != 3'd0 && pend_next && age_next >= timeout_reg;
        dec_sym_next = code_lookup(bits_elem, cnt_elem);
        bits_next    = bits_elem;
        seq_cnt_next = cnt_elem;
        if (dec_do_next) begin
            bits_next    = '0;
            seq_cnt_next = '0;
            pend_next    = 1'b0;
            age_next     = '0;
        end

        dec_store     = dec_do_next && dec_sym_next != '0 && msg_not_full;
        cnt_after_dec = msg_cnt_reg + MSG_CNT_W'(dec_store);

        enter_hold_next = enter_hold_reg;
        enter_prev_next = enter_prev_reg;
        space_do_next   = 1'b0;
        send_do_next    = 1'b0;
        if (enter_en_reg) begin
            if (!enter_level && enter_prev_reg) begin
                enter_hold_next = '0;
            end else if (!enter_level) begin
                enter_hold_next = dur_enter;
            end else if (!enter_prev_reg && dur_enter > glitch_reg) begin
                if (dur_enter >= long_reg) begin
                    send_do_next = cnt_after_dec != '0;
                end else begin
                    space_do_next = 1'b1;
                end
            end
            enter_prev_next = enter_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_prev_reg   <= 1'b1;
            key_hold_reg   <= '0;
            bits_reg       <= '0;
            seq_cnt_reg    <= '0;
            pend_reg       <= 1'b0;
            age_reg        <= '0;
            enter_prev_reg <= 1'b1;
            enter_hold_reg <= '0;
            elem_do_reg    <= 1'b0;
            dec_do_reg     <= 1'b0;
            space_do_reg   <= 1'b0;
            send_do_reg    <= 1'b0;
        end else if (cmd.accept) begin
            key_prev_reg   <= key_prev_next;
            key_hold_reg   <= key_hold_next;
            bits_reg       <= bits_next;
            seq_cnt_reg    <= seq_cnt_next;
            pend_reg       <= pend_next;
            age_reg        <= age_next;
            enter_prev_reg <= enter_prev_next;
            enter_hold_reg <= enter_hold_next;
            elem_do_reg    <= elem_do_next;
            dec_do_reg     <= dec_do_next;
            space_do_reg   <= space_do_next;
            send_do_reg    <= send_do_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            dash_reg    <= dash_next;
            dec_sym_reg <= dec_sym_next;
        end
    end

    always_comb begin
        store_we   = 1'b0;
        store_data = ASCII_SPACE;
        if (cmd.emit && msg_not_full) begin
            if (cmd.out_sel == OUT_DEC && dec_sym_reg != '0) begin
                store_we   = 1'b1;
                store_data = dec_sym_reg;
            end else if (cmd.out_sel == OUT_SPACE) begin
                store_we = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            msg_mem[msg_cnt_reg[MSG_IDX_W-1:0]] <= store_data;
        end
        rd_data_reg <= msg_mem[rd_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msg_cnt_reg <= '0;
            rd_idx_reg  <= '0;
        end else begin
            if (cmd.send_end) begin
                msg_cnt_reg <= '0;
            end else if (store_we) begin
                msg_cnt_reg <= msg_cnt_reg + 1'b1;
            end
            if (cmd.accept) begin
                rd_idx_reg <= '0;
            end else if (cmd.send_next) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
        end
    end

    always_comb begin
        unique case (cmd.out_sel)
            OUT_ELEM: begin
                out_event = dash_reg ? EV_DASH : EV_DOT;
                out_sym   = '0;
            end
            OUT_DEC: begin
                out_event = (dec_sym_reg != '0) ? EV_CHAR : EV_UNKNOWN;
                out_sym   = dec_sym_reg;
            end
            OUT_SPACE: begin
                out_event = EV_SPACE;
                out_sym   = ASCII_SPACE;
            end
            OUT_MSG: begin
                out_event = EV_MSG;
                out_sym   = rd_data_reg;
            end
            default: begin
                out_event = EV_DOT;
                out_sym   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_event_reg <= out_event;
            m_sym_reg   <= out_sym;
            m_tlast_reg <= cmd.emit_last;
        end
    end

    assign status.elem_do   = elem_do_reg;
    assign status.dec_do    = dec_do_reg;
    assign status.space_do  = space_do_reg;
    assign status.send_do   = send_do_reg;
    assign status.send_last = {1'b0, rd_idx_reg} == MSG_CNT_W'(msg_cnt_reg - 1'b1);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_sym_reg};
    assign m_tuser  = m_event_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== src/morse_key_decoder.sv =====
// Top level of the straight-key Morse decoder with message store.
//
//  channel  dir  handshake           payload
//  s_       in   s_tvalid/s_tready   s_tdata: key_level, enter_level
//  m_       out  m_tvalid/m_tready   m_tdata: symbol; m_tuser: event_res; m_tlast: last
//  cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// An item is taken in the idle state, then the controller walks the element,
// decode and space slots in order before it takes the next item.
// A long enter press adds a store read and an output load per stored character.
// Reset is synchronous, active low; the store needs no clearing pass.
// Output backpressure holds the controller in its current slot.
`timescale 1ns / 1ps

module morse_key_decoder
    import mkd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [0] key_level, [1] enter_level
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [6:0] symbol
    output logic [2:0]       m_tuser,   // [2:0] event_res
    output logic             m_tlast,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       unused_tdata;

    assign cfg_ready    = 1'b1;
    assign unused_tdata = ^s_tdata[7:2];

    mkd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mkd_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .key_level   (s_tdata[0]),
        .enter_level (s_tdata[1]),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("result loaded into a full output register");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> !s_tready)
        else $error("item taken while previous item still in work");

    a_send_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.send_end |-> (cmd.emit && cmd.emit_last))
        else $error("message burst ended without a final result");

endmodule

// ===== tb/morse_key_decoder_test.sv =====
// Self-checking testbench for the Morse key decoder: predicts result streams from key and enter ticks.
`timescale 1ns / 1ps

module morse_key_decoder_test;
    import mkd_pkg::*;

    localparam int         CYCLE_LIMIT  = 200_000;
    localparam int         DRAIN_CYCLES = 80;
    localparam int         SHOW_LIMIT   = 10;
    localparam logic [2:0] CFG_SPARE    = 3'd5;

    class key_decoder_scoreboard;
        typedef struct {
            event_t           ev;
            logic [SYM_W-1:0] sym;
            logic             last;
        } decoder_event_t;

        string codes [CODE_NUM];

        logic [15:0]      dot_max, decode_gap, glitch, long_press;
        logic             enter_en;
        logic             key_prev, enter_prev, act_pending;
        logic [15:0]      key_hold, enter_hold, act_age;
        logic [5:0]       elem_bits;
        logic [2:0]       elem_cnt;
        logic [SYM_W-1:0] store [MSG_DEPTH];
        logic [5:0]       msg_count;

        decoder_event_t   burst [$];
        decoder_event_t   events_due [$];
        int               ticks, checked, mismatches, reg_writes;

        function new();
            codes = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
                      "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
                      "..-", "...-", ".--", "-..-", "-.--", "--..",
                      "-----", ".----", "..---", "...--", "....-",
                      ".....", "-....", "--...", "---..", "----."};
            dot_max     = DOT_MAX_RST;
            decode_gap  = TIMEOUT_RST;
            glitch      = GLITCH_RST;
            long_press  = LONG_RST;
            enter_en    = 1'b1;
            key_prev    = 1'b1;
            enter_prev  = 1'b1;
            act_pending = 1'b0;
            key_hold    = '0;
            enter_hold  = '0;
            act_age     = '0;
            elem_bits   = '0;
            elem_cnt    = '0;
            msg_count   = '0;
        endfunction

        function logic [15:0] bump(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function void emit(event_t ev, logic [SYM_W-1:0] sym);
            decoder_event_t e;
            e.ev   = ev;
            e.sym  = sym;
            e.last = 1'b0;
            burst.push_back(e);
        endfunction

        function void append(logic [SYM_W-1:0] ch);
            if (msg_count < MSG_DEPTH) begin
                store[msg_count] = ch;
                msg_count++;
            end
        endfunction

        function logic [SYM_W-1:0] match_sequence();
            bit ok;
            if (elem_cnt == 0 || elem_cnt > SEQ_MAX) return '0;
            for (int i = 0; i < CODE_NUM; i++) begin
                if (codes[i].len() == elem_cnt) begin
                    ok = 1'b1;
                    for (int j = 0; j < elem_cnt; j++) begin
                        if ((codes[i][j] == "-") != elem_bits[j]) ok = 1'b0;
                    end
                    if (ok) return (i < 26) ? SYM_W'(ASCII_A + i) : SYM_W'(ASCII_0 + i - 26);
                end
            end
            return '0;
        endfunction

        function void take_register(logic [2:0] idx, logic [15:0] val);
            reg_writes++;
            case (idx)
                CFG_DOT_MAX:  dot_max    = val;
                CFG_TIMEOUT:  decode_gap = val;
                CFG_GLITCH:   glitch     = val;
                CFG_LONG:     long_press = val;
                CFG_ENTER_EN: enter_en   = val[0];
                default: ;
            endcase
        endfunction

        function void take_tick(logic key, logic ent);
            logic [15:0]      dur;
            logic             dash;
            logic [SYM_W-1:0] ch;
            burst.delete();
            ticks++;
            if (act_pending) act_age = bump(act_age);

            if (!key && key_prev) begin
                key_hold = '0;
            end else if (!key) begin
                key_hold = bump(key_hold);
            end else if (!key_prev) begin
                dur = bump(key_hold);
                if (dur > glitch) begin
                    dash = dur > dot_max;
                    if (elem_cnt < SEQ_MAX) begin
                        elem_bits[elem_cnt] = dash;
                        elem_cnt++;
                    end else begin
                        elem_cnt = SEQ_OVF;
                    end
                    act_pending = 1'b1;
                    act_age     = '0;
                    emit(dash ? EV_DASH : EV_DOT, '0);
                end
            end
            key_prev = key;

            if (key && elem_cnt != 0 && act_pending && act_age >= decode_gap) begin
                ch = match_sequence();
                if (ch != 0) begin
                    append(ch);
                    emit(EV_CHAR, ch);
                end else begin
                    emit(EV_UNKNOWN, '0);
                end
                elem_bits   = '0;
                elem_cnt    = '0;
                act_pending = 1'b0;
                act_age     = '0;
            end

            if (enter_en) begin
                if (!ent && enter_prev) begin
                    enter_hold = '0;
                end else if (!ent) begin
                    enter_hold = bump(enter_hold);
                end else if (!enter_prev) begin
                    dur = bump(enter_hold);
                    if (dur > glitch) begin
                        if (dur >= long_press) begin
                            for (int i = 0; i < msg_count; i++) emit(EV_MSG, store[i]);
                            msg_count = '0;
                        end else begin
                            append(ASCII_SPACE);
                            emit(EV_SPACE, ASCII_SPACE);
                        end
                    end
                end
                enter_prev = ent;
            end

            if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i]) events_due.push_back(burst[i]);
        endfunction

        function void check_event(logic [2:0] ev, logic [SYM_W-1:0] sym, logic last);
            decoder_event_t want;
            checked++;
            if (events_due.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("Unexpected result %0d: event %0d symbol %02h last %0b",
                             checked, ev, sym, last);
            end else begin
                want = events_due.pop_front();
                if (ev !== want.ev || sym !== want.sym || last !== want.last) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display({"Mismatch at result %0d: expected event %0d symbol %02h ",
                                  "last %0b, got event %0d symbol %02h last %0b"},
                                 checked, want.ev, want.sym, want.last, ev, sym, last);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [0] key_level, [1] enter_level
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [6:0] symbol
    logic [2:0]  m_tuser;   // [2:0] event_res
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    key_decoder_scoreboard sb;
    bit key_q [$];
    bit ent_q [$];
    bit no_stall;
    int cur_dot, cur_gap, cur_glitch, cur_long;

    morse_key_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= no_stall || ($urandom_range(99) >= 6);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.take_tick(s_tdata[0], s_tdata[1]);
            if (m_tvalid && m_tready) sb.check_event(m_tuser, m_tdata[6:0], m_tlast);
            if (cfg_valid && cfg_ready) sb.take_register(cfg_index, cfg_data);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Timed out after %0d cycles", CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_timing(input int dot, input int gap, input int glitch,
                                input int long_press, input bit en);
        cur_dot    = dot;
        cur_gap    = gap;
        cur_glitch = glitch;
        cur_long   = long_press;
        write_reg(CFG_DOT_MAX, 16'(dot));
        write_reg(CFG_TIMEOUT, 16'(gap));
        write_reg(CFG_GLITCH, 16'(glitch));
        write_reg(CFG_LONG, 16'(long_press));
        write_reg(CFG_ENTER_EN, {15'd0, en});
    endtask

    task automatic send_tick(input bit key, input bit ent);
        if (!no_stall && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, ent, key};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic push_levels(input string keys, input string ents);
        for (int i = 0; i < keys.len(); i++) begin
            key_q.push_back(keys[i] != "0");
            ent_q.push_back(ents[i] != "0");
        end
    endtask

    task automatic play_levels();
        foreach (key_q[i]) send_tick(key_q[i], ent_q[i]);
        s_tvalid <= 1'b0;
        key_q.delete();
        ent_q.delete();
    endtask

    task automatic settle();
        while (sb.events_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Key side: mostly table characters, some random element runs and noise.
    // Enter side runs in parallel with short, long and glitch presses.
    task automatic build_random(input int target, input int long_pct, input bit send_at_end);
        bit    elems [$];
        string code;
        bit    dash;
        int    d, g, dash_lo;
        dash_lo = ((cur_dot > cur_glitch) ? cur_dot : cur_glitch) + 1;
        while (key_q.size() < target) begin
            elems.delete();
            if ($urandom_range(99) < 8) begin
                repeat ($urandom_range(2, 6)) key_q.push_back(1'($urandom_range(1)));
                key_q.push_back(1'b1);
                continue;
            end
            if ($urandom_range(99) < 12) begin
                repeat ($urandom_range(1, 8)) elems.push_back(1'($urandom_range(1)));
            end else begin
                code = sb.codes[$urandom_range(CODE_NUM - 1)];
                for (int j = 0; j < code.len(); j++) elems.push_back(code[j] == "-");
            end
            foreach (elems[j]) begin
                dash = elems[j] || cur_dot <= cur_glitch;
                if (cur_glitch > 0 && $urandom_range(99) < 8) begin
                    repeat ($urandom_range(1, cur_glitch)) key_q.push_back(1'b0);
                    key_q.push_back(1'b1);
                end
                d = dash ? $urandom_range(dash_lo, dash_lo + 1)
                         : $urandom_range(cur_glitch + 1, cur_dot);
                repeat (d) key_q.push_back(1'b0);
                if (j == elems.size() - 1) g = cur_gap + 1 + $urandom_range(2);
                else g = $urandom_range(1, (cur_gap > 0) ? cur_gap : 1);
                repeat (g) key_q.push_back(1'b1);
            end
        end
        while (ent_q.size() < key_q.size()) begin
            repeat ($urandom_range(1, 8)) ent_q.push_back(1'b1);
            if ($urandom_range(99) < long_pct) d = $urandom_range(cur_long, cur_long + 2);
            else if (cur_long - 1 > cur_glitch) d = $urandom_range(cur_glitch + 1, cur_long - 1);
            else d = $urandom_range(1, cur_long + 1);
            if (cur_glitch > 0 && $urandom_range(99) < 8) d = $urandom_range(1, cur_glitch);
            repeat (d) ent_q.push_back(1'b0);
            ent_q.push_back(1'b1);
        end
        if (send_at_end) begin
            repeat (cur_long + 1) ent_q.push_back(1'b0);
            ent_q.push_back(1'b1);
        end
        while (key_q.size() < ent_q.size()) key_q.push_back(1'b1);
        while (ent_q.size() < key_q.size()) ent_q.push_back(1'b1);
        repeat (cur_gap + 2) begin
            key_q.push_back(1'b1);
            ent_q.push_back(1'b1);
        end
    endtask

    initial begin
        sb        = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        no_stall  = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset timing: short presses fall under the glitch filter
        push_levels("0001111", "1100011");
        play_levels();
        settle();

        apply_timing(1, 1, 0, 4, 1);
        write_reg(CFG_SPARE, 16'hFFFF);
        push_levels("011", "111");
        push_levels("0011", "0011");
        push_levels("010011", "100001");
        push_levels("111111", "000011");
        play_levels();
        settle();

        build_random(150, 0, 1'b1);
        play_levels();
        settle();

        // zero timeout, every press a dash, every enter press a send
        no_stall = 1'b1;
        apply_timing(0, 0, 0, 1, 1);
        build_random(35, 50, 1'b0);
        play_levels();
        settle();
        no_stall = 1'b0;

        apply_timing(4, 3, 2, 6, 0);
        build_random(35, 30, 1'b1);
        play_levels();
        settle();

        apply_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
        push_levels("0001100111", "1000011111");
        play_levels();
        settle();

        apply_timing(2, 2, 1, 5, 1);
        build_random(50, 10, 1'b1);
        play_levels();
        settle();

        $display("Run covered %0d ticks, %0d checked results and %0d register writes,",
                 sb.ticks, sb.checked, sb.reg_writes);
        $display({"with element overflow, store fill, zero timeout, enter disabled ",
                  "and maximum settings (%0d mismatches)."}, sb.mismatches);
        if (sb.mismatches == 0 && sb.events_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (sb.events_due.size() != 0)
                $display("%0d expected results never arrived", sb.events_due.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mkd_pkg.sv
src/mkd_ctrl.sv
src/mkd_datapath.sv
src/morse_key_decoder.sv
tb/morse_key_decoder_test.sv
